@@ sv/pomo_pkg.sv @@
// ----------------------------------------------------------------------------
// pomo_pkg
// Shared widths, constants, codes and item types of the countdown timer.
// ----------------------------------------------------------------------------
package pomo_pkg;

  // Field widths.
  localparam int unsigned SEC_W      = 17;
  localparam int unsigned CHUNK_W    = 17;
  localparam int unsigned BREAK_W    = 16;
  localparam int unsigned HOURS_W    = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 1;

  // Time constants.
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;

  // Register reset values: a 25 minute work chunk and a 5 minute break.
  localparam logic [CHUNK_W-1:0] WORK_CHUNK_RST = CHUNK_W'(25 * 60);
  localparam logic [BREAK_W-1:0] BREAK_RST      = BREAK_W'(5 * 60);

  // Reciprocals for the constant divisions of a 17-bit second count.
  // floor(x * RECIP / 2^SHIFT) equals floor(x / divisor) for every 17-bit x.
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned PROD_W      = SEC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] HOUR_RECIP = RECIP_W'(149131);
  localparam int unsigned HOUR_SHIFT  = 29;
  localparam logic [RECIP_W-1:0] MIN_RECIP  = RECIP_W'(139811);
  localparam int unsigned MIN_SHIFT   = 23;
  // Quotient widths: up to 36 whole hours and 2184 whole minutes.
  localparam int unsigned HQ_W        = PROD_W - HOUR_SHIFT;
  localparam int unsigned TM_W        = PROD_W - MIN_SHIFT;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORK_CHUNK = 1'b0,
    CFG_BREAK      = 1'b1
  } cfg_idx_t;

  // Kind of an input item.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  // Timer status after one item, passed from the control stage on.
  typedef struct packed {
    logic [SEC_W-1:0] interval;
    logic             on_break;
    logic             active;
    logic             alarm;
    logic             done;
  } timer_stat_t;

  // One result item.
  typedef struct packed {
    logic               done_res;
    logic               alarm;
    logic               active;
    logic               on_break;
    logic [MIN_W-1:0]   show_seconds;
    logic [MIN_W-1:0]   show_minutes;
    logic [HOURS_W-1:0] show_hours;
    logic [SEC_W-1:0]   interval_left;
  } timer_res_t;

endpackage

@@ sv/pomo_ctrl.sv @@
// ----------------------------------------------------------------------------
// pomo_ctrl
// Timer state, configuration registers and the per-item state update.
// ----------------------------------------------------------------------------
module pomo_ctrl import pomo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  op_t                   op,
  input  logic [HOURS_W-1:0]    start_hours,
  input  logic [MIN_W-1:0]      start_minutes,
  input  logic                  use_breaks,
  output logic                  stat_valid,
  output timer_stat_t           stat,
  input  logic                  stat_ready
);

  logic [CHUNK_W-1:0] work_chunk;
  logic [BREAK_W-1:0] break_len;

  logic               running;
  logic               break_mode;
  logic               in_break;
  logic [SEC_W-1:0]   interval_count;
  logic [SEC_W-1:0]   work_budget;

  logic               running_next;
  logic               break_mode_next;
  logic               in_break_next;
  logic [SEC_W-1:0]   interval_count_next;
  logic [SEC_W-1:0]   work_budget_next;
  logic               alarm_next;
  logic               done_next;

  logic               take;
  logic [SEC_W-1:0]   start_budget;
  logic [SEC_W-1:0]   start_interval;
  logic [SEC_W-1:0]   resume_interval;

  assign take     = in_valid && in_ready;
  assign in_ready = !stat_valid || stat_ready;

  // Budget of a start item; at most 115380 seconds, so it fits exactly.
  assign start_budget = SEC_W'(start_hours) * SEC_W'(SEC_PER_HOUR)
                      + SEC_W'(start_minutes) * SEC_W'(SEC_PER_MIN);

  // First work interval of a start and the next work chunk after a break.
  assign start_interval  = (use_breaks && (start_budget > work_chunk)) ?
                           work_chunk : start_budget;
  assign resume_interval = (work_budget > work_chunk) ? work_chunk : work_budget;

  // Next state for the item being taken.
  always_comb begin
    running_next        = running;
    break_mode_next     = break_mode;
    in_break_next       = in_break;
    interval_count_next = interval_count;
    work_budget_next    = work_budget;
    alarm_next          = 1'b0;
    done_next           = 1'b0;
    if (take) begin
      if (op == OP_START) begin
        work_budget_next = start_budget;
        in_break_next    = 1'b0;
        if (start_budget != '0) begin
          break_mode_next     = use_breaks;
          interval_count_next = start_interval;
          running_next        = 1'b1;
        end
      end else if (running) begin
        if (interval_count != '0) begin
          interval_count_next = interval_count - SEC_W'(1);
          if (!in_break && (work_budget != '0)) begin
            work_budget_next = work_budget - SEC_W'(1);
          end
        end else begin
          // Interval expired: go to a break, back to work, or finish.
          alarm_next = 1'b1;
          if (!break_mode) begin
            done_next = 1'b1;
          end else if (!in_break) begin
            if (work_budget != '0) begin
              in_break_next       = 1'b1;
              interval_count_next = SEC_W'(break_len);
            end else begin
              done_next = 1'b1;
            end
          end else begin
            in_break_next = 1'b0;
            if (resume_interval != '0) begin
              interval_count_next = resume_interval;
            end else begin
              done_next = 1'b1;
            end
          end
          if (done_next) begin
            running_next = 1'b0;
          end
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_chunk <= WORK_CHUNK_RST;
      break_len  <= BREAK_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WORK_CHUNK: work_chunk <= cfg_data;
        CFG_BREAK:      break_len  <= cfg_data[BREAK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Timer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      break_mode     <= 1'b0;
      in_break       <= 1'b0;
      interval_count <= '0;
      work_budget    <= '0;
    end else begin
      running        <= running_next;
      break_mode     <= break_mode_next;
      in_break       <= in_break_next;
      interval_count <= interval_count_next;
      work_budget    <= work_budget_next;
    end
  end

  // Status register toward the display split.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (in_ready) begin
      stat_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stat.interval <= interval_count_next;
      stat.on_break <= in_break_next;
      stat.active   <= running_next;
      stat.alarm    <= alarm_next;
      stat.done     <= done_next;
    end
  end

endmodule

@@ sv/pomo_split.sv @@
// ----------------------------------------------------------------------------
// pomo_split
// Splits the interval into hours, minutes and seconds over two stages.
// ----------------------------------------------------------------------------
module pomo_split import pomo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        stat_valid,
  input  timer_stat_t stat,
  output logic        stat_ready,
  output logic        res_valid,
  output timer_res_t  res,
  input  logic        res_ready
);

  logic               mid_valid;
  timer_stat_t        mid_stat;
  logic [HQ_W-1:0]    mid_hq;
  logic [TM_W-1:0]    mid_tm;

  logic               mid_ready;
  logic               out_ready;
  logic [PROD_W-1:0]  hour_prod;
  logic [PROD_W-1:0]  min_prod;
  logic [TM_W-1:0]    min_part;
  logic [SEC_W-1:0]   sec_part;

  assign out_ready  = !res_valid || res_ready;
  assign mid_ready  = !mid_valid || out_ready;
  assign stat_ready = mid_ready;

  // Whole hours and whole minutes by reciprocal multiplication.
  assign hour_prod = PROD_W'(stat.interval) * PROD_W'(HOUR_RECIP);
  assign min_prod  = PROD_W'(stat.interval) * PROD_W'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= stat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && stat_valid) begin
      mid_stat <= stat;
      mid_hq   <= hour_prod[PROD_W-1:HOUR_SHIFT];
      mid_tm   <= min_prod[PROD_W-1:MIN_SHIFT];
    end
  end

  // Minutes within the hour and seconds within the minute.
  assign min_part = mid_tm - TM_W'(mid_hq) * TM_W'(SEC_PER_MIN);
  assign sec_part = mid_stat.interval - SEC_W'(mid_tm) * SEC_W'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mid_valid) begin
      res.interval_left <= mid_stat.interval;
      res.show_hours    <= mid_hq[HOURS_W-1:0];
      res.show_minutes  <= min_part[MIN_W-1:0];
      res.show_seconds  <= sec_part[MIN_W-1:0];
      res.on_break      <= mid_stat.on_break;
      res.active        <= mid_stat.active;
      res.alarm         <= mid_stat.alarm;
      res.done_res      <= mid_stat.done;
    end
  end

endmodule

@@ sv/pomodoro_countdown_timer.sv @@
// ----------------------------------------------------------------------------
// pomodoro_countdown_timer
// Countdown timer with optional work/break alternation and h:m:s display.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects the item kind (0 = one-second tick,
// 1 = start). A start carries hours, minutes and the work/break mode in
// s_tdata. Every input item yields exactly one result item on the output
// stream with the interval left, its hours/minutes/seconds split, the break
// and running flags, and the alarm and done flags of that item.
// The configuration port writes the work chunk length (index 0) and the
// break length (index 1); write it only while no item is in flight.
// From input accept to result valid an item passes through the state
// update stage, the reciprocal-multiply stage and the result register.
// One item per cycle when not stalled; the state update is a combinational
// compare, decrement and select, so consecutive ticks run back to back.
// When the receiver stalls, the result register holds and the two stages
// behind it keep filling; s_tready falls only once all three are full.
// Synchronous reset stops the timer, clears the interval and budget, sets
// the registers to 1500 s and 300 s, and empties the pipeline.
// ----------------------------------------------------------------------------
module pomodoro_countdown_timer import pomo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input items.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // start_hours[4:0], start_minutes[10:5], use_breaks[11], zero[15:12]
  input  logic [15:0]           s_tdata,
  // op[0]
  input  logic [0:0]            s_tuser,
  // Result items.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // interval_left[16:0], show_hours[21:17], show_minutes[27:22],
  // show_seconds[33:28], on_break[34], active[35], alarm[36],
  // done_res[37], zero[39:38]
  output logic [39:0]           m_tdata
);

  logic        stat_valid;
  logic        stat_ready;
  timer_stat_t stat;
  timer_res_t  res;

  pomo_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .op            (op_t'(s_tuser[0])),
    .start_hours   (s_tdata[4:0]),
    .start_minutes (s_tdata[10:5]),
    .use_breaks    (s_tdata[11]),
    .stat_valid    (stat_valid),
    .stat          (stat),
    .stat_ready    (stat_ready)
  );

  pomo_split u_split (
    .clk        (clk),
    .rst        (rst),
    .stat_valid (stat_valid),
    .stat       (stat),
    .stat_ready (stat_ready),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  // Pack the result item, last field (interval_left) in the lowest bits.
  assign m_tdata = {2'b00, res};

  // A finished task is an expired interval and leaves the timer stopped.
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.done_res) |-> (res.alarm && !res.active))
    else $error("done result without alarm or with timer still active");

  // A break only exists while the timer runs.
  a_break_active: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.on_break) |-> res.active)
    else $error("break flag set on a stopped timer");

  // The display split stays within a minute and an hour.
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.show_minutes < MIN_W'(SEC_PER_MIN)) &&
                  (res.show_seconds < MIN_W'(SEC_PER_MIN))))
    else $error("minutes or seconds out of range");

  // A status item taken from the control stage always reaches the middle stage.
  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    (stat_valid && stat_ready) |=> u_split.mid_valid)
    else $error("status item lost between stages");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pomodoro countdown timer.
// ----------------------------------------------------------------------------
// Items go in on the input stream and results come back on the output stream.
// A behavioral copy of the timer runs beside the block and predicts one
// result per accepted item. A checker compares every result field with the
// oldest prediction. A directed part covers the corner cases. Three random
// phases follow, each with its own register setting and its own stall
// pattern on both streams; the last phase runs without stalls.
// ----------------------------------------------------------------------------
module tb;
  import pomo_pkg::*;

  localparam int unsigned RESULT_LATENCY = 3;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // start_hours[4:0], start_minutes[10:5], use_breaks[11], zero[15:12]
  logic [15:0]           s_tdata = '0;
  // op[0]
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // interval_left[16:0], show_hours[21:17], show_minutes[27:22],
  // show_seconds[33:28], on_break[34], active[35], alarm[36],
  // done_res[37], zero[39:38]
  logic [39:0]           m_tdata;

  pomodoro_countdown_timer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #2 clk = ~clk;

  // Predicted timer state and register copies.
  logic [CHUNK_W-1:0] chunk_len    = WORK_CHUNK_RST;
  logic [BREAK_W-1:0] break_len    = BREAK_RST;
  logic               tm_running   = 1'b0;
  logic               tm_breaks_on = 1'b0;
  logic               tm_in_break  = 1'b0;
  logic [SEC_W-1:0]   tm_count     = '0;
  logic [SEC_W-1:0]   tm_budget    = '0;

  timer_res_t  timer_results_q[$];
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned cycles        = 0;

  // Advance the timer copy by one item and return the result it shows.
  function automatic timer_res_t timer_next(op_t op, logic [HOURS_W-1:0] hrs,
                                            logic [MIN_W-1:0] mins, logic brk);
    timer_res_t       res;
    logic             raise_alarm;
    logic             finish;
    logic [SEC_W-1:0] next_len;
    int unsigned      secs;
    raise_alarm = 1'b0;
    finish      = 1'b0;
    if (op == OP_START) begin
      secs        = hrs * SEC_PER_HOUR + mins * SEC_PER_MIN;
      tm_budget   = secs[SEC_W-1:0];
      tm_in_break = 1'b0;
      if (tm_budget != 0) begin
        tm_breaks_on = brk;
        tm_count     = (brk && tm_budget > chunk_len) ? chunk_len : tm_budget;
        tm_running   = 1'b1;
      end
    end else if (tm_running) begin
      if (tm_count > 0) begin
        tm_count = tm_count - 1'b1;
        if (!tm_in_break && tm_budget > 0) tm_budget = tm_budget - 1'b1;
      end else begin
        raise_alarm = 1'b1;
        if (!tm_breaks_on) begin
          finish = 1'b1;
        end else if (!tm_in_break) begin
          // Work interval over: take a break if budget is left.
          if (tm_budget > 0) begin
            tm_in_break = 1'b1;
            tm_count    = SEC_W'(break_len);
          end else begin
            finish = 1'b1;
          end
        end else begin
          // Break over: go back to the next work chunk.
          next_len    = (tm_budget > chunk_len) ? chunk_len : tm_budget;
          tm_in_break = 1'b0;
          if (next_len > 0) tm_count = next_len;
          else finish = 1'b1;
        end
        if (finish) tm_running = 1'b0;
      end
    end
    secs              = tm_count / SEC_PER_HOUR;
    res.show_hours    = secs[HOURS_W-1:0];
    secs              = (tm_count % SEC_PER_HOUR) / SEC_PER_MIN;
    res.show_minutes  = secs[MIN_W-1:0];
    secs              = tm_count % SEC_PER_MIN;
    res.show_seconds  = secs[MIN_W-1:0];
    res.interval_left = tm_count;
    res.on_break      = tm_in_break;
    res.active        = tm_running;
    res.alarm         = raise_alarm;
    res.done_res      = finish;
    return res;
  endfunction

  // Send one item, holding it until the block takes it.
  task automatic send_item(op_t op, logic [HOURS_W-1:0] hrs,
                           logic [MIN_W-1:0] mins, logic brk);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {4'b0000, brk, mins, hrs};
    do @(posedge clk); while (!s_tready);
    timer_results_q.push_back(timer_next(op, hrs, mins, brk));
    items_sent++;
  endtask

  // Stop sending and wait until every result is back and the pipe is empty.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (timer_results_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_WORK_CHUNK) chunk_len = value;
    else break_len = value[BREAK_W-1:0];
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Ticks on an idle timer and a start with zero budget change nothing.
  task automatic test_idle_and_zero_start();
    send_item(OP_TICK, 5'd31, 6'd63, 1'b1);
    send_item(OP_START, 5'd0, 6'd0, 1'b1);
    send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
  endtask

  // A short work chunk, a break, and the return to work.
  task automatic test_work_break_cycle();
    wait_drained();
    write_reg(CFG_WORK_CHUNK, 17'd2);
    write_reg(CFG_BREAK, 17'd1);
    send_item(OP_START, 5'd0, 6'd1, 1'b1);
    repeat (5) send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
  endtask

  // A zero-budget start keeps the interval going, and its expiry finishes.
  task automatic test_zero_budget_restart();
    send_item(OP_START, 5'd0, 6'd0, 1'b0);
    repeat (4) send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
  endtask

  // Zero work chunk and zero break: each interval expires on the next tick.
  task automatic test_zero_lengths();
    wait_drained();
    write_reg(CFG_WORK_CHUNK, 17'd0);
    write_reg(CFG_BREAK, 17'd0);
    send_item(OP_START, 5'd0, 6'd1, 1'b1);
    repeat (2) send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
    send_item(OP_START, 5'd0, 6'd1, 1'b0);
    send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
  endtask

  // Largest registers and starts; the hour display wraps past 31 hours.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(CFG_WORK_CHUNK, 17'h1FFFF);
    write_reg(CFG_BREAK, 17'h1FFFF);
    send_item(OP_START, 5'd31, 6'd63, 1'b1);
    send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
    send_item(OP_START, 5'd23, 6'd59, 1'b0);
    send_item(OP_TICK, 5'd0, 6'd0, 1'b0);
    send_item(OP_START, 5'd31, 6'd63, 1'b0);
  endtask

  // Mostly short tasks followed by runs of ticks, with some random starts.
  task automatic test_random_tasks(int unsigned n_items, int unsigned src_pct,
                                   int unsigned sink_pct, logic [CHUNK_W-1:0] chunk,
                                   logic [CHUNK_W-1:0] brk_len);
    int unsigned stop_at;
    int unsigned ticks;
    wait_drained();
    write_reg(CFG_WORK_CHUNK, chunk);
    write_reg(CFG_BREAK, brk_len);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        send_item(OP_START, 5'd0, 6'($urandom_range(1, 2)), $urandom_range(99) < 80);
        ticks = $urandom_range(20, 140);
      end else begin
        send_item(OP_START, 5'($urandom_range(31)), 6'($urandom_range(63)),
                  1'($urandom_range(1)));
        ticks = $urandom_range(0, 15);
      end
      repeat (ticks) begin
        if ($urandom_range(99) < 3)
          send_item(OP_START, 5'd0, 6'd0, 1'($urandom_range(1)));
        else
          send_item(OP_TICK, 5'($urandom_range(31)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
      end
    end
  endtask

  // Receiver stalls.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin : check_results
    timer_res_t got;
    timer_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = timer_res_t'(m_tdata[$bits(timer_res_t)-1:0]);
      if (timer_results_q.size() == 0) begin
        $error("result item with no item waiting for it");
        mismatches++;
      end else begin
        want = timer_results_q.pop_front();
        check_field("interval_left", want.interval_left, got.interval_left);
        check_field("show_hours", want.show_hours, got.show_hours);
        check_field("show_minutes", want.show_minutes, got.show_minutes);
        check_field("show_seconds", want.show_seconds, got.show_seconds);
        check_field("on_break", want.on_break, got.on_break);
        check_field("active", want.active, got.active);
        check_field("alarm", want.alarm, got.alarm);
        check_field("done_res", want.done_res, got.done_res);
      end
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    src_idle_pct  = 12;
    sink_idle_pct = 52;
    test_idle_and_zero_start();
    test_work_break_cycle();
    test_zero_budget_restart();
    test_zero_lengths();
    test_register_extremes();
    test_random_tasks(460, 12, 52, 17'd5, 17'd2);
    test_random_tasks(460, 52, 12, 17'd1, 17'd0);
    test_random_tasks(460, 0, 0, 17'($urandom_range(1, 20)), 17'($urandom_range(0, 10)));
    wait_drained();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && timer_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
